>>> rtl/core/dis_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the delimited identifier scanner.
// No dependencies; every other file in rtl/core imports this package.
package dis_pkg;

    localparam int CHAR_W = 21;
    localparam int POS_W  = 32;

    localparam logic [CHAR_W-1:0] EOF_CODE   = 21'h00FFFF;
    localparam logic [CHAR_W-1:0] CLOSE_CODE = 21'h00007D;

    typedef enum logic [1:0] {
        KIND_BODY     = 2'd0,
        KIND_END      = 2'd1,
        KIND_EOF_ERR  = 2'd2,
        KIND_OVERFLOW = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [CHAR_W-1:0] body_char;
        logic [POS_W-1:0]  start_pos;
        logic [POS_W-1:0]  end_pos;
        logic              last;
    } result_t;

endpackage

>>> rtl/core/dis_in_if.sv
`timescale 1ns / 1ps
// Input channel of the scanner: one code point and its source position per beat.
// Depends on dis_pkg for the field widths.
interface dis_in_if;
    import dis_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic [POS_W-1:0]  position;

    modport source (output valid, output character, output position, input ready);
    modport sink   (input valid, input character, input position, output ready);
endinterface

>>> rtl/core/dis_out_if.sv
`timescale 1ns / 1ps
// Result channel of the scanner: one body character or token event per beat.
// Depends on dis_pkg for the field widths.
interface dis_out_if;
    import dis_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [CHAR_W-1:0] body_char;
    logic [POS_W-1:0]  start_pos;
    logic [POS_W-1:0]  end_pos;
    logic              last;

    modport source (output valid, output kind, output body_char, output start_pos,
                    output end_pos, output last, input ready);
    modport sink   (input valid, input kind, input body_char, input start_pos,
                    input end_pos, input last, output ready);
endinterface

>>> rtl/core/delimited_identifier_scanner.sv
`timescale 1ns / 1ps
// Delimited identifier scanner: captures a delimiter up to '}', then streams
// the body delayed by the delimiter length until the delimiter reappears.
// Depends on dis_pkg, dis_in_if and dis_out_if.
//
//   channel  | dir | fields                                      | beats per item
//   ---------+-----+---------------------------------------------+---------------
//   chars    | in  | character[20:0], position[31:0]             | 1
//   tokens   | out | kind[1:0], body_char[20:0], start_pos[31:0],| 0, 1 or 2
//            |     | end_pos[31:0], last                         |
//
// An accepted beat waits in the input register, where the window shift, the
// parallel delimiter compare and the result selection run, until the result register
// is empty or hands over its last pending result; the beat then loads the result register.
// One item per cycle sustained while tokens.ready holds; an item that yields two
// results holds the result register for two output beats, which sets the rate then.
// Reset clears the mode, counters and valid flags; the delimiter and window
// payload registers are not reset. A stalled output holds the result
// register while an empty input register still takes one more beat.
module delimited_identifier_scanner #(
    parameter int MAX_DELIM = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    dis_in_if.sink    chars,
    dis_out_if.source tokens
);
    import dis_pkg::*;

    localparam int LEN_W = $clog2(MAX_DELIM + 1);

    // Input register
    logic              in_valid_reg, in_valid_next;
    logic [CHAR_W-1:0] char_reg;
    logic [POS_W-1:0]  pos_reg;

    // Scanner state
    logic              scanning_reg, scanning_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  fill_reg, fill_next;
    logic [POS_W-1:0]  start_reg, start_next;
    logic              have_start_reg, have_start_next;
    logic [CHAR_W-1:0] delim_reg [MAX_DELIM];
    logic [CHAR_W-1:0] delim_next [MAX_DELIM];
    logic [CHAR_W-1:0] window_reg [MAX_DELIM];
    logic [CHAR_W-1:0] window_next [MAX_DELIM];

    // Result register: up to two results, head always in slot 0
    result_t           slot0_reg, slot0_next;
    result_t           slot1_reg, slot1_next;
    logic [1:0]        rem_reg, rem_next;

    // Per-item results
    result_t           res0, res1;
    logic [1:0]        res_cnt;

    logic              accept, advance, pop;
    logic              is_eof, is_close;
    logic [POS_W-1:0]  start_eff;
    logic              zero_match, shift_match;

    assign pop     = (rem_reg != 2'd0) && tokens.ready;
    assign advance = in_valid_reg && ((rem_reg == 2'd0) || ((rem_reg == 2'd1) && pop));
    assign accept  = chars.valid && chars.ready;

    assign chars.ready = !in_valid_reg || advance;

    assign tokens.valid     = (rem_reg != 2'd0);
    assign tokens.kind      = slot0_reg.kind;
    assign tokens.body_char = slot0_reg.body_char;
    assign tokens.start_pos = slot0_reg.start_pos;
    assign tokens.end_pos   = slot0_reg.end_pos;
    assign tokens.last      = slot0_reg.last;

    assign is_eof    = (char_reg == EOF_CODE);
    assign is_close  = (char_reg == CLOSE_CODE);
    assign start_eff = have_start_reg ? start_reg : pos_reg;

    // Shifted window and both compares: the zero-filled window seen at '}'
    // and the window after this body character moves in.
    always_comb
    begin
        zero_match  = 1'b1;
        shift_match = 1'b1;
        for (int i = 0; i < MAX_DELIM; i++)
        begin
            if (LEN_W'(i + 1) < len_reg)
                window_next[i] = window_reg[i + 1 < MAX_DELIM ? i + 1 : i];
            else if (LEN_W'(i + 1) == len_reg)
                window_next[i] = char_reg;
            else
                window_next[i] = window_reg[i];
            if (LEN_W'(i) < len_reg)
            begin
                zero_match  = zero_match  && (delim_reg[i] == '0);
                shift_match = shift_match && (window_next[i] == delim_reg[i]);
            end
        end
    end

    // Next state and results for the item in the input register
    always_comb
    begin
        scanning_next   = scanning_reg;
        len_next        = len_reg;
        fill_next       = fill_reg;
        start_next      = start_reg;
        have_start_next = have_start_reg;
        for (int i = 0; i < MAX_DELIM; i++)
        begin
            delim_next[i] = delim_reg[i];
        end
        res0    = '{kind: KIND_BODY, body_char: '0, start_pos: start_eff,
                     end_pos: '0, last: 1'b1};
        res1    = '{kind: KIND_END, body_char: '0, start_pos: start_eff,
                     end_pos: pos_reg, last: 1'b1};
        res_cnt = 2'd0;

        if (is_eof)
        begin
            res0.kind       = KIND_EOF_ERR;
            res0.end_pos    = pos_reg;
            res_cnt         = 2'd1;
            scanning_next   = 1'b0;
            len_next        = '0;
            fill_next       = '0;
            have_start_next = 1'b0;
        end
        else
        begin
            start_next      = start_eff;
            have_start_next = 1'b1;
            if (!scanning_reg)
            begin
                if (is_close)
                begin
                    scanning_next = 1'b1;
                    fill_next     = '0;
                    // Empty or all-NUL delimiter ends the token right here
                    if (zero_match)
                    begin
                        res0.kind       = KIND_END;
                        res0.end_pos    = pos_reg;
                        res_cnt         = 2'd1;
                        scanning_next   = 1'b0;
                        len_next        = '0;
                        have_start_next = 1'b0;
                    end
                end
                else if (len_reg < LEN_W'(MAX_DELIM))
                begin
                    for (int i = 0; i < MAX_DELIM; i++)
                    begin
                        if (len_reg == LEN_W'(i))
                            delim_next[i] = char_reg;
                    end
                    len_next = len_reg + LEN_W'(1);
                end
                else
                begin
                    res0.kind    = KIND_OVERFLOW;
                    res0.end_pos = pos_reg;
                    res_cnt      = 2'd1;
                end
            end
            else
            begin
                // Oldest character drops out once the window is full
                if (len_reg != '0 && fill_reg == len_reg)
                begin
                    res0.body_char = window_reg[0];
                    res_cnt        = 2'd1;
                end
                else if (len_reg != '0)
                begin
                    fill_next = fill_reg + LEN_W'(1);
                end
                if (shift_match)
                begin
                    if (res_cnt == 2'd1)
                    begin
                        res0.last = 1'b0;
                        res_cnt   = 2'd2;
                    end
                    else
                    begin
                        res0     = res1;
                        res_cnt  = 2'd1;
                    end
                    scanning_next   = 1'b0;
                    len_next        = '0;
                    fill_next       = '0;
                    have_start_next = 1'b0;
                end
            end
        end
    end

    // Result register and input register control
    always_comb
    begin
        slot0_next    = slot0_reg;
        slot1_next    = slot1_reg;
        rem_next      = rem_reg;
        in_valid_next = in_valid_reg;
        if (advance)
        begin
            slot0_next = res0;
            slot1_next = res1;
            rem_next   = res_cnt;
        end
        else if (pop)
        begin
            slot0_next = slot1_reg;
            rem_next   = rem_reg - 2'd1;
        end
        if (accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            rem_reg        <= 2'd0;
            scanning_reg   <= 1'b0;
            len_reg        <= '0;
            fill_reg       <= '0;
            start_reg      <= '0;
            have_start_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            rem_reg      <= rem_next;
            if (advance)
            begin
                scanning_reg   <= scanning_next;
                len_reg        <= len_next;
                fill_reg       <= fill_next;
                start_reg      <= start_next;
                have_start_reg <= have_start_next;
            end
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            char_reg <= chars.character;
            pos_reg  <= chars.position;
        end
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
        if (advance && !is_eof)
        begin
            for (int i = 0; i < MAX_DELIM; i++)
            begin
                delim_reg[i] <= delim_next[i];
                // Zero-fill the window at '}', shift it during the body
                if (!scanning_reg)
                    window_reg[i] <= is_close ? '0 : window_reg[i];
                else
                    window_reg[i] <= window_next[i];
            end
        end
    end

    // Checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= len_reg)
        else $error("window fill exceeds delimiter length");

    a_body_has_delim: assert property (@(posedge clk) disable iff (!rst_n)
        scanning_reg |-> (len_reg != '0))
        else $error("body scan with empty delimiter");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (rem_reg == 2'd2) |-> (!slot0_reg.last && slot1_reg.last))
        else $error("two pending results with wrong last marks");

    a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(char_reg)
                                         && $stable(pos_reg)))
        else $error("pending input item lost or changed");

endmodule
